>>> rtl/hysteresis_thermostat_guard_macros.svh
// Assertion macros used by the top level of the thermostat guard RTL.
`ifndef HYSTERESIS_THERMOSTAT_GUARD_MACROS_SVH
`define HYSTERESIS_THERMOSTAT_GUARD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thermostat guard assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thermostat guard assertion failed");

`endif

>>> rtl/htg_pkg.sv
// Package with the types, codes and helpers of the thermostat guard.
`default_nettype none

package htg_pkg;

    localparam int unsigned NUM_REGS   = 5;
    localparam int unsigned ADDR_WIDTH = 5;
    localparam int unsigned DATA_WIDTH = 32;

    localparam logic [2:0] REG_LOW_LIMIT    = 3'd0;
    localparam logic [2:0] REG_HIGH_LIMIT   = 3'd1;
    localparam logic [2:0] REG_HYSTERESIS   = 3'd2;
    localparam logic [2:0] REG_MIN_ON_TIME  = 3'd3;
    localparam logic [2:0] REG_MIN_OFF_TIME = 3'd4;

    localparam logic OP_UPDATE    = 1'b0;
    localparam logic OP_FORCE_OFF = 1'b1;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_HEATING  = 2'd1;
    localparam logic [1:0] MODE_OVERHEAT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'b001,
        ST_HEATING  = 3'b010,
        ST_OVERHEAT = 3'b100
    } state_t;

    typedef struct packed {
        logic signed [15:0] low_limit;
        logic signed [15:0] high_limit;
        logic [11:0]        hysteresis;
        logic [31:0]        min_on_time;
        logic [31:0]        min_off_time;
    } cfg_t;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        now_ms;
        logic signed [15:0] temperature;
        logic               temp_valid;
    } item_t;

    typedef struct packed {
        state_t      mode;
        logic [31:0] last_switch;
    } guard_state_t;

    function automatic logic [1:0] mode_code(input state_t st);
        logic [1:0] code;
        case (st)
            ST_IDLE:     code = MODE_IDLE;
            ST_HEATING:  code = MODE_HEATING;
            ST_OVERHEAT: code = MODE_OVERHEAT;
            default:     code = MODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/htg_cfg.sv
// Configuration register file of the thermostat guard behind its APB-style port.
`default_nettype none

module htg_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [htg_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [htg_pkg::DATA_WIDTH-1:0] pwdata,
    output logic      [htg_pkg::DATA_WIDTH-1:0] prdata,
    output logic                               pready,
    output htg_pkg::cfg_t                      cfg
);
    import htg_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[4:2];
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_LOW_LIMIT:    cfg_next.low_limit    = pwdata[15:0];
                REG_HIGH_LIMIT:   cfg_next.high_limit   = pwdata[15:0];
                REG_HYSTERESIS:   cfg_next.hysteresis   = pwdata[11:0];
                REG_MIN_ON_TIME:  cfg_next.min_on_time  = pwdata;
                REG_MIN_OFF_TIME: cfg_next.min_off_time = pwdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_LOW_LIMIT:    prdata = {16'd0, cfg_reg.low_limit};
            REG_HIGH_LIMIT:   prdata = {16'd0, cfg_reg.high_limit};
            REG_HYSTERESIS:   prdata = {20'd0, cfg_reg.hysteresis};
            REG_MIN_ON_TIME:  prdata = cfg_reg.min_on_time;
            REG_MIN_OFF_TIME: prdata = cfg_reg.min_off_time;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_limit    <= 16'sd320;
            cfg_reg.high_limit   <= 16'sd560;
            cfg_reg.hysteresis   <= 12'd16;
            cfg_reg.min_on_time  <= 32'd60000;
            cfg_reg.min_off_time <= 32'd60000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/htg_decide.sv
// Next-state logic of the thermostat guard for one request.
`default_nettype none

module htg_decide (
    input  wire htg_pkg::cfg_t         cfg,
    input  wire htg_pkg::item_t        item,
    input  wire htg_pkg::guard_state_t cur,
    output htg_pkg::guard_state_t      nxt
);
    import htg_pkg::*;

    logic signed [17:0] temp_ext;
    logic signed [17:0] low_ext;
    logic signed [17:0] high_ext;
    logic signed [17:0] hyst_ext;
    logic signed [17:0] low_enter;
    logic signed [17:0] low_exit;
    logic signed [17:0] high_enter;
    logic signed [17:0] high_exit;
    logic [31:0]        elapsed;
    logic               on_ok;
    logic               off_ok;
    logic               off_zero;
    logic               below_low_enter;
    logic               at_low_exit;
    logic               above_high_enter;
    logic               at_high_exit;
    logic               first_switch;

    assign temp_ext  = {{2{item.temperature[15]}}, item.temperature};
    assign low_ext   = {{2{cfg.low_limit[15]}}, cfg.low_limit};
    assign high_ext  = {{2{cfg.high_limit[15]}}, cfg.high_limit};
    assign hyst_ext  = {6'd0, cfg.hysteresis};

    assign low_enter  = low_ext - hyst_ext;
    assign low_exit   = low_ext + hyst_ext;
    assign high_enter = high_ext + hyst_ext;
    assign high_exit  = high_ext - hyst_ext;

    assign below_low_enter  = temp_ext < low_enter;
    assign at_low_exit      = temp_ext >= low_exit;
    assign above_high_enter = temp_ext > high_enter;
    assign at_high_exit     = temp_ext <= high_exit;

    assign elapsed  = item.now_ms - cur.last_switch;
    assign on_ok    = elapsed >= cfg.min_on_time;
    assign off_ok   = elapsed >= cfg.min_off_time;
    assign off_zero = cfg.min_off_time == 32'd0;

    // A second switch within one request starts from idle with no time elapsed.
    always_comb
    begin
        nxt          = cur;
        first_switch = 1'b0;
        if (item.opcode == OP_FORCE_OFF)
        begin
            nxt.mode        = ST_IDLE;
            nxt.last_switch = item.now_ms;
        end
        else if (item.temp_valid)
        begin
            case (cur.mode)
                ST_IDLE:
                begin
                    if (below_low_enter)
                    begin
                        if (off_ok)
                        begin
                            nxt.mode        = ST_HEATING;
                            nxt.last_switch = item.now_ms;
                        end
                    end
                    else if (above_high_enter && off_ok)
                    begin
                        nxt.mode        = ST_OVERHEAT;
                        nxt.last_switch = item.now_ms;
                    end
                end
                ST_HEATING:
                begin
                    first_switch = at_low_exit && on_ok;
                    if (first_switch)
                    begin
                        nxt.mode        = ST_IDLE;
                        nxt.last_switch = item.now_ms;
                    end
                    if (above_high_enter && (first_switch ? off_zero : on_ok))
                    begin
                        nxt.mode        = ST_OVERHEAT;
                        nxt.last_switch = item.now_ms;
                    end
                end
                ST_OVERHEAT:
                begin
                    first_switch = at_high_exit && on_ok;
                    if (first_switch)
                    begin
                        nxt.mode        = ST_IDLE;
                        nxt.last_switch = item.now_ms;
                    end
                    if (below_low_enter && (first_switch ? off_zero : on_ok))
                    begin
                        nxt.mode        = ST_HEATING;
                        nxt.last_switch = item.now_ms;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/hysteresis_thermostat_guard.sv
// Top level of the thermostat guard: request register, mode state and result register.
// A request waits in the request register; its result is registered when it advances.
// One request per cycle unless the result stalls; the mode update is one pass of compares
// and adds. A stalled result still lets an empty request register take one more request.
// Reset (asynchronous, active low) sets idle mode, switch time zero and the default limits.
`default_nettype none

`include "hysteresis_thermostat_guard_macros.svh"

module hysteresis_thermostat_guard (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [htg_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [htg_pkg::DATA_WIDTH-1:0] pwdata,
    output logic      [htg_pkg::DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic                           opcode,
    input  wire logic [31:0]                    now_ms,
    input  wire logic signed [15:0]             temperature,
    input  wire logic                           temp_valid,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [1:0]                          mode,
    output logic                                heater_on,
    output logic [31:0]                         last_change_ms
);
    import htg_pkg::*;

    cfg_t         cfg;
    item_t        item_reg;
    item_t        item_next;
    logic         item_valid_reg;
    logic         item_valid_next;
    guard_state_t state_reg;
    guard_state_t state_next;
    logic         result_valid_reg;
    logic         result_valid_next;
    logic [1:0]   mode_reg;
    logic         heater_on_reg;
    logic [31:0]  last_change_reg;
    logic         out_free;
    logic         accept;
    logic         advance;

    htg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    htg_decide u_decide (
        .cfg  (cfg),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = item_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;
    assign advance    = item_valid_reg && out_free;

    assign item_next.opcode      = opcode;
    assign item_next.now_ms      = now_ms;
    assign item_next.temperature = temperature;
    assign item_next.temp_valid  = temp_valid;

    assign item_valid_next   = accept || (item_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    assign result_valid   = result_valid_reg;
    assign mode           = mode_reg;
    assign heater_on      = heater_on_reg;
    assign last_change_ms = last_change_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg        <= 1'b0;
            result_valid_reg      <= 1'b0;
            state_reg.mode        <= ST_IDLE;
            state_reg.last_switch <= 32'd0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            mode_reg        <= mode_code(state_next.mode);
            heater_on_reg   <= state_next.mode == ST_HEATING;
            last_change_reg <= state_next.last_switch;
        end
    end

    `HTG_ASSERT_SAME(a_heater_matches_mode, result_valid, heater_on == (mode == MODE_HEATING))
    `HTG_ASSERT_NEXT(a_force_off_idle, advance && item_reg.opcode == OP_FORCE_OFF, mode == MODE_IDLE && last_change_ms == $past(item_reg.now_ms))
    `HTG_ASSERT_NEXT(a_state_holds, !advance, $stable(state_reg.mode) && $stable(state_reg.last_switch))
    `HTG_ASSERT_NEXT(a_result_follows_state, advance, last_change_ms == state_reg.last_switch && mode == mode_code(state_reg.mode))

endmodule

`default_nettype wire
